>>> hdl/adsr_envelope_level_core_macros.svh
// Assertion macros for the ADSR envelope level core.
`ifndef ADSR_ENVELOPE_LEVEL_CORE_MACROS_SVH
`define ADSR_ENVELOPE_LEVEL_CORE_MACROS_SVH
`ifndef SYNTH
`define ADSR_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("adsr: invariant violated");
`define ADSR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adsr: implication violated");
`else
`define ADSR_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ADSR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/adsr_pkg.sv
// Shared widths, constants and word types of the ADSR envelope level core.
`default_nettype none
package adsr_pkg;

  localparam int TIME_W    = 32;
  localparam int DUR_W     = 24;
  localparam int LVL_W     = 16;
  localparam int QUO_W     = 17;
  localparam int BACK_W    = 40;
  localparam int REM_W     = DUR_W + QUO_W;
  localparam int PROD_W    = BACK_W + LVL_W;
  localparam int SLOPE_W   = LVL_W + 1;
  localparam int PART_W    = DUR_W + 1 + SLOPE_W;
  localparam int NUM_W     = PROD_W + 1;
  localparam int SUM_W     = QUO_W + 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [LVL_W-1:0]  FULL_SCALE = 16'd32768;
  localparam logic [LVL_W-1:0]  CUTOFF_LSB = 16'd3;
  // 2^39 is beyond 32768 times any duration, so a longer look-back clamps anyway
  localparam logic [BACK_W-1:0] BACK_MAX   = 40'h80_0000_0000;

  localparam logic [DUR_W-1:0] ATTACK_RST  = 24'd4800;
  localparam logic [DUR_W-1:0] DECAY_RST   = 24'd480;
  localparam logic [DUR_W-1:0] REL_RST     = 24'd960;
  localparam logic [LVL_W-1:0] SUSTAIN_RST = 16'd26214;
  localparam logic [LVL_W-1:0] PEAK_RST    = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK  = 3'd0,
    CFG_DECAY   = 3'd1,
    CFG_RELEASE = 3'd2,
    CFG_SUSTAIN = 3'd3,
    CFG_PEAK    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [DUR_W-1:0] attack_ticks;
    logic [DUR_W-1:0] decay_ticks;
    logic [DUR_W-1:0] rel_ticks;
    logic [LVL_W-1:0] sustain_level;
    logic [LVL_W-1:0] peak_level;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ticks;
    logic [TIME_W-1:0] press_ticks;
    logic [TIME_W-1:0] lift_ticks;
  } in_word_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             still_active;
  } out_word_t;

  // level = base + floor((m0a*m0b + m1a*m1b) / div)
  typedef struct packed {
    logic               dead;
    logic [LVL_W-1:0]   base;
    logic [BACK_W-1:0]  m0a;
    logic [LVL_W-1:0]   m0b;
    logic [DUR_W-1:0]   m1a;
    logic [SLOPE_W-1:0] m1b;
    logic [DUR_W-1:0]   div;
  } op_t;

endpackage
`default_nettype wire

>>> hdl/adsr_fifo.sv
// Small register queue used between the front, the back and the result port.
`default_nettype none
module adsr_fifo #(
  parameter int  DEPTH  = 4,
  parameter type word_t = logic [7:0]
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  output logic  full,
  input  word_t wr_data,
  input  logic  pop,
  output logic  empty,
  output word_t rd_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  word_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

>>> hdl/adsr_front.sv
// Front end: registers an input word, picks the envelope segment and forms the operands.
`default_nettype none
module adsr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  adsr_pkg::cfg_t   cfg,
  input  logic             in_push,
  output logic             in_full,
  input  adsr_pkg::in_word_t in_data,
  output logic             op_push,
  input  logic             op_full,
  output adsr_pkg::op_t    op_data
);
  import adsr_pkg::*;

  localparam int DW = TIME_W + 1;
  localparam int WW = DW + BACK_W;

  logic                 v_r, v_nxt;
  in_word_t             in_r;
  logic                 advance;
  logic                 take;
  logic                 held;
  logic [DUR_W-1:0]     a, d, r;
  logic signed [DW-1:0] life, since;
  logic signed [DW-1:0] a_s, ad_s, r_s;
  logic signed [DW-1:0] life_minus_a, r_minus_since;
  logic [DW-1:0]        back_mag;
  logic [WW-1:0]        back_wide;
  logic [BACK_W-1:0]    back_sat;
  op_t                  op;

  assign advance = !v_r || !op_full;
  assign take    = in_push && advance;
  assign in_full = !advance;
  assign op_push = v_r && !op_full;
  assign op_data = op;
  assign v_nxt   = take || (v_r && op_full);

  always_comb begin
    // a zero duration acts as one tick
    a = (cfg.attack_ticks == '0) ? DUR_W'(1) : cfg.attack_ticks;
    d = (cfg.decay_ticks == '0) ? DUR_W'(1) : cfg.decay_ticks;
    r = (cfg.rel_ticks == '0) ? DUR_W'(1) : cfg.rel_ticks;

    held  = in_r.lift_ticks < in_r.press_ticks;
    life  = $signed({1'b0, in_r.now_ticks}) - $signed({1'b0, in_r.press_ticks});
    since = $signed({1'b0, in_r.now_ticks}) - $signed({1'b0, in_r.lift_ticks});

    a_s  = $signed(DW'(a));
    ad_s = $signed(DW'(a) + DW'(d));
    r_s  = $signed(DW'(r));

    life_minus_a  = life - a_s;
    r_minus_since = r_s - since;

    back_mag  = $unsigned(-since);
    back_wide = WW'(back_mag);
    back_sat  = (back_wide > WW'(BACK_MAX)) ? BACK_MAX : back_wide[BACK_W-1:0];

    op      = '0;
    op.div  = DUR_W'(1);
    if (held) begin
      priority if (life < 0) begin
        op.dead = 1'b1;
      end else if (life <= a_s) begin
        op.m0a = BACK_W'(life[DUR_W-1:0]);
        op.m0b = cfg.peak_level;
        op.div = a;
      end else if (life <= ad_s) begin
        op.m0a = BACK_W'(d);
        op.m0b = cfg.peak_level;
        op.m1a = life_minus_a[DUR_W-1:0];
        op.m1b = SLOPE_W'($signed({1'b0, cfg.sustain_level}) -
                          $signed({1'b0, cfg.peak_level}));
        op.div = d;
      end else begin
        op.base = cfg.sustain_level;
      end
    end else begin
      priority if (since >= r_s) begin
        op.dead = 1'b1;
      end else if (since >= 0) begin
        op.m0a = BACK_W'(r_minus_since[DUR_W-1:0]);
        op.m0b = cfg.sustain_level;
        op.div = r;
      end else begin
        // before the lift: extend the release line backwards above sustain
        op.m0a  = back_sat;
        op.m0b  = cfg.sustain_level;
        op.base = cfg.sustain_level;
        op.div  = r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_r <= in_data;
    end
  end

endmodule
`default_nettype wire

>>> hdl/adsr_back.sv
// Back end: multiply, pipelined restoring divide, clamp and cutoff into result words.
`default_nettype none
module adsr_back #(
  parameter int OUT_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                op_empty,
  output logic                op_pop,
  input  adsr_pkg::op_t       op_data,
  output logic                res_push,
  output adsr_pkg::out_word_t res_data,
  input  logic                res_taken
);
  import adsr_pkg::*;

  localparam int CRD_W = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic              dead;
    logic [LVL_W-1:0]  base;
    logic [PROD_W-1:0] p0;
    logic [PART_W-1:0] p1;
    logic [DUR_W-1:0]  div;
  } mul_t;

  typedef struct packed {
    logic             dead;
    logic             ovf;
    logic [LVL_W-1:0] base;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [DUR_W-1:0] div;
  } dvs_t;

  logic [CRD_W-1:0]            credit_r, credit_nxt;
  logic                        issue;
  logic                        s1_v_r;
  mul_t                        s1_r, s1_nxt;
  logic                        dv_v_r [QUO_W+1];
  dvs_t                        dv_r [QUO_W+1];
  dvs_t                        s2_nxt;
  logic signed [NUM_W-1:0]     num;
  logic signed [PART_W-1:0]    part;
  logic [QUO_W-1:0]            quo_fin;
  logic [SUM_W-1:0]            sum;

  // credits cover every word in flight plus every word parked in the result queue
  assign issue      = !op_empty && (credit_r < CRD_W'(OUT_DEPTH));
  assign op_pop     = issue;
  assign credit_nxt = credit_r + CRD_W'(issue) - CRD_W'(res_taken);

  always_comb begin
    part        = PART_W'($signed({1'b0, op_data.m1a})) * PART_W'($signed(op_data.m1b));
    s1_nxt.dead = op_data.dead;
    s1_nxt.base = op_data.base;
    s1_nxt.p0   = PROD_W'(op_data.m0a) * PROD_W'(op_data.m0b);
    s1_nxt.p1   = $unsigned(part);
    s1_nxt.div  = op_data.div;
  end

  always_comb begin
    num         = $signed({1'b0, s1_r.p0}) + NUM_W'($signed(s1_r.p1));
    s2_nxt.dead = s1_r.dead;
    s2_nxt.base = s1_r.base;
    s2_nxt.div  = s1_r.div;
    s2_nxt.quo  = '0;
    // quotient wider than the divider bits: saturate, the clamp takes it from here
    s2_nxt.ovf  = $unsigned(num) >= NUM_W'({s1_r.div, {QUO_W{1'b0}}});
    s2_nxt.rem  = num[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r  <= '0;
      s1_v_r    <= 1'b0;
      dv_v_r[0] <= 1'b0;
    end else begin
      credit_r  <= credit_nxt;
      s1_v_r    <= issue;
      dv_v_r[0] <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r     <= s1_nxt;
    dv_r[0]  <= s2_nxt;
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_div
    localparam int BIT = QUO_W - k;
    logic [REM_W-1:0] shifted;
    logic             fits;
    dvs_t             nxt;

    always_comb begin
      shifted      = REM_W'(dv_r[k-1].div) << BIT;
      fits         = dv_r[k-1].rem >= shifted;
      nxt          = dv_r[k-1];
      nxt.rem      = fits ? dv_r[k-1].rem - shifted : dv_r[k-1].rem;
      nxt.quo[BIT] = fits;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      dv_r[k] <= nxt;
    end
  end

  always_comb begin
    quo_fin  = dv_r[QUO_W].ovf ? '1 : dv_r[QUO_W].quo;
    sum      = SUM_W'(dv_r[QUO_W].base) + SUM_W'(quo_fin);
    res_data = '0;
    priority if (dv_r[QUO_W].dead) begin
      res_data.level        = '0;
      res_data.still_active = 1'b0;
    end else if (sum > SUM_W'(FULL_SCALE)) begin
      res_data.level        = FULL_SCALE;
      res_data.still_active = 1'b1;
    end else if (sum <= SUM_W'(CUTOFF_LSB)) begin
      res_data.level        = '0;
      res_data.still_active = 1'b0;
    end else begin
      res_data.level        = sum[LVL_W-1:0];
      res_data.still_active = 1'b1;
    end
  end

  assign res_push = dv_v_r[QUO_W];

endmodule
`default_nettype wire

>>> hdl/adsr_envelope_level_core.sv
// Top level of the ADSR envelope level core: config registers, front, queues and back.
//
//   channel  direction  handshake            word
//   in       input      in_push / in_full    now, press and lift ticks
//   out      output     out_pop / out_empty  level and still_active
//   cfg      input      cfg_valid/cfg_ready  register index and data
//
// One word is taken per clock and one result leaves per clock, sustained, while out_pop stays high.
// A taken word passes the front register, the middle queue, the multiply register,
// the divider setup register and the 17-stage restoring divider to the result queue.
// Synchronous active-low reset restores the register defaults and empties all queues.
// A stalled result side fills the result queue; the back then stops issuing,
// the middle queue fills and in_full rises. cfg_ready is always high.
`default_nettype none
`include "adsr_envelope_level_core_macros.svh"
module adsr_envelope_level_core #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  adsr_pkg::in_word_t                   in_data,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output adsr_pkg::out_word_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [adsr_pkg::DUR_W-1:0]           cfg_data
);
  import adsr_pkg::*;

  cfg_t      cfg_r;
  logic      op_push, mid_full, mid_empty, op_pop;
  op_t       op_wr, op_rd;
  logic      res_push, out_full, res_taken;
  out_word_t res_word;
  logic      out_code_ok;

  assign cfg_ready = 1'b1;
  assign res_taken = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_ticks  <= ATTACK_RST;
      cfg_r.decay_ticks   <= DECAY_RST;
      cfg_r.rel_ticks     <= REL_RST;
      cfg_r.sustain_level <= SUSTAIN_RST;
      cfg_r.peak_level    <= PEAK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ATTACK:  cfg_r.attack_ticks  <= cfg_data;
        CFG_DECAY:   cfg_r.decay_ticks   <= cfg_data;
        CFG_RELEASE: cfg_r.rel_ticks     <= cfg_data;
        CFG_SUSTAIN: cfg_r.sustain_level <= cfg_data[LVL_W-1:0];
        CFG_PEAK:    cfg_r.peak_level    <= cfg_data[LVL_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  adsr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .op_push (op_push),
    .op_full (mid_full),
    .op_data (op_wr)
  );

  adsr_fifo #(
    .DEPTH  (MID_DEPTH),
    .word_t (op_t)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .full    (mid_full),
    .wr_data (op_wr),
    .pop     (op_pop),
    .empty   (mid_empty),
    .rd_data (op_rd)
  );

  adsr_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_empty  (mid_empty),
    .op_pop    (op_pop),
    .op_data   (op_rd),
    .res_push  (res_push),
    .res_data  (res_word),
    .res_taken (res_taken)
  );

  adsr_fifo #(
    .DEPTH  (OUT_DEPTH),
    .word_t (out_word_t)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .full    (out_full),
    .wr_data (res_word),
    .pop     (out_pop),
    .empty   (out_empty),
    .rd_data (out_data)
  );

  assign out_code_ok = out_data.still_active ?
                       (out_data.level > CUTOFF_LSB && out_data.level <= FULL_SCALE) :
                       (out_data.level == '0);

  `ADSR_ASSERT_IMPLY(a_res_room, clk, rst_n, res_push, !out_full)
  `ADSR_ASSERT_IMPLY(a_op_room, clk, rst_n, op_push, !mid_full)
  `ADSR_ASSERT_IMPLY(a_out_code, clk, rst_n, !out_empty, out_code_ok)

endmodule
`default_nettype wire

>>> bench/tb_adsr_envelope_level_core.sv
// Self-checking bench for the ADSR envelope level core: directed, register and random notes.
module tb_adsr_envelope_level_core;
  timeunit 1ns;
  timeprecision 1ps;
  import adsr_pkg::*;

  localparam int     CYCLE_LIMIT   = 600_000;
  localparam int     LONG_HOLD     = 300;
  localparam int     DRAIN_CYCLES  = 50;
  localparam int     REPORT_MAX    = 10;
  localparam int     CFG_IDX_TOP   = (1 << CFG_IDX_W) - 1;
  localparam longint BACK_CAP      = longint'(1) << 40;
  localparam logic [DUR_W-1:0] DUR_MAX = '1;

  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_BURSTY} rx_style_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_push   = 1'b0;
  logic                 in_full;
  in_word_t             in_data   = '0;
  logic                 out_empty;
  logic                 out_pop   = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DUR_W-1:0]     cfg_data  = '0;

  // register copies, tracked from accepted config writes
  logic [DUR_W-1:0] cur_attack  = ATTACK_RST;
  logic [DUR_W-1:0] cur_decay   = DECAY_RST;
  logic [DUR_W-1:0] cur_release = REL_RST;
  logic [LVL_W-1:0] cur_sustain = SUSTAIN_RST;
  logic [LVL_W-1:0] cur_peak    = PEAK_RST;

  out_word_t expected_levels[$];
  int        mismatches  = 0;
  int        notes_sent  = 0;
  int        words_read  = 0;
  int        reg_writes  = 0;
  int        cycles      = 0;

  logic      hold_start  = 1'b0;
  int        hold_left   = 0;
  int        stall_left  = 0;
  rx_style_t rx_style    = RX_STREAM;

  adsr_envelope_level_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Exact envelope level for one note word under the current registers.
  function automatic out_word_t predict_level(in_word_t w);
    longint    a, d, r, pk, su, dt, v, back;
    out_word_t res;
    a  = (cur_attack == '0) ? 1 : longint'(cur_attack);
    d  = (cur_decay == '0) ? 1 : longint'(cur_decay);
    r  = (cur_release == '0) ? 1 : longint'(cur_release);
    pk = longint'(cur_peak);
    su = longint'(cur_sustain);
    if (w.lift_ticks < w.press_ticks) begin
      dt = longint'(w.now_ticks) - longint'(w.press_ticks);
      if (dt < 0) v = -1;
      else if (dt <= a) v = (dt * pk) / a;
      else if (dt <= a + d) v = (pk * d + (dt - a) * (su - pk)) / d;
      else v = su;
    end else begin
      dt = longint'(w.now_ticks) - longint'(w.lift_ticks);
      if (dt >= r) v = -1;
      else if (dt >= 0) v = (su * (r - dt)) / r;
      else begin
        // extend the release line backwards
        back = -dt;
        if (back > BACK_CAP) back = BACK_CAP;
        v = su + (su * back) / r;
      end
    end
    if (v > longint'(FULL_SCALE)) v = longint'(FULL_SCALE);
    res.still_active = 1'b1;
    if (v <= longint'(CUTOFF_LSB)) begin
      v = 0;
      res.still_active = 1'b0;
    end
    res.level = v[LVL_W-1:0];
    return res;
  endfunction

  // Note word aimed at the phase boundaries of the current envelope, with some noise.
  function automatic in_word_t make_note_word();
    in_word_t    w;
    longint      a, d, r, press, lift, off;
    int unsigned pick;
    a = (cur_attack == '0) ? 1 : longint'(cur_attack);
    d = (cur_decay == '0) ? 1 : longint'(cur_decay);
    r = (cur_release == '0) ? 1 : longint'(cur_release);
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      w.now_ticks   = $urandom();
      w.press_ticks = $urandom();
      w.lift_ticks  = $urandom();
      return w;
    end
    press = longint'($urandom_range(32'h7FFF_FFFF, 1));
    if (pick < 56) begin
      lift = longint'($urandom_range(0, 32'(press - 1)));
      case ($urandom_range(0, 6))
        0:       off = longint'($urandom_range(0, 32'(a)));
        1:       off = a + longint'($urandom_range(0, 6)) - 3;
        2:       off = a + d + longint'($urandom_range(0, 6)) - 3;
        3:       off = a + longint'($urandom_range(0, 32'(d)));
        4:       off = -longint'($urandom_range(1, 64));
        5:       off = a + d + longint'($urandom_range(0, 1 << 20));
        default: off = longint'($urandom_range(0, 3));
      endcase
      w.now_ticks = 32'(press + off);
    end else begin
      lift = press + ((pick < 70) ? 0 : longint'($urandom_range(0, 1 << 20)));
      case ($urandom_range(0, 5))
        0:       off = longint'($urandom_range(0, 32'(r)));
        1:       off = r + longint'($urandom_range(0, 6)) - 3;
        2:       off = r - 1 - longint'($urandom_range(0, 3));
        3:       off = -longint'($urandom_range(1, 32'(r)));
        4:       off = -longint'($urandom_range(1, 1 << 30));
        default: off = longint'($urandom_range(0, 3));
      endcase
      w.now_ticks = 32'(lift + off);
    end
    w.press_ticks = 32'(press);
    w.lift_ticks  = 32'(lift);
    return w;
  endfunction

  // Leaves in_push high; wait_idle lowers it.
  task automatic send_word(input in_word_t w);
    in_push <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic note(input logic [TIME_W-1:0] now_t, press_t, lift_t);
    in_word_t w;
    w.now_ticks   = now_t;
    w.press_ticks = press_t;
    w.lift_ticks  = lift_t;
    send_word(w);
  endtask

  task automatic send_stream(input int count, input bit steady);
    int burst;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        if (!steady && $urandom_range(0, 2) != 0) begin
          in_push <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        burst = $urandom_range(1, 40);
      end
      send_word(make_note_word());
      burst--;
    end
  endtask

  // Drop push and hold until every outstanding word is back.
  task automatic wait_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_envelope(input logic [DUR_W-1:0] a, d, r, su, pk);
    write_reg(CFG_ATTACK, a);
    write_reg(CFG_DECAY, d);
    write_reg(CFG_RELEASE, r);
    write_reg(CFG_SUSTAIN, su);
    write_reg(CFG_PEAK, pk);
  endtask

  task automatic random_config();
    logic [DUR_W-1:0] vals[5];
    int unsigned      pick;
    for (int i = 0; i < 5; i++) begin
      vals[i] = DUR_W'($urandom());
      pick = $urandom_range(0, 9);
      if (i <= int'(CFG_RELEASE)) begin
        if (pick == 0) vals[i] = '0;
        else if (pick <= 6) vals[i] = DUR_W'($urandom_range(1, 64));
        else if (pick <= 8) vals[i] = DUR_W'($urandom_range(65, 5000));
        else vals[i] = DUR_W'($urandom_range(5001, DUR_MAX));
      end else begin
        // upper data bits stay random; the block keeps only the low 16
        if (pick <= 7) vals[i][LVL_W-1:0] = LVL_W'($urandom_range(0, 32768));
        else if (pick == 8) vals[i][LVL_W-1:0] = LVL_W'($urandom_range(0, 8));
        else vals[i][LVL_W-1:0] = LVL_W'($urandom_range(32769, 65535));
      end
    end
    set_envelope(vals[0], vals[1], vals[2], vals[3], vals[4]);
  endtask

  // Reset registers: every envelope phase and its boundaries, then the cutoff edge.
  task automatic test_envelope_shape();
    note(32'd1000, 32'd1000, 32'd0);
    note(32'd999, 32'd1000, 32'd0);
    note(32'd1001, 32'd1000, 32'd0);
    note(32'd3400, 32'd1000, 32'd0);
    note(32'd5800, 32'd1000, 32'd0);
    note(32'd5801, 32'd1000, 32'd0);
    note(32'd6280, 32'd1000, 32'd0);
    note(32'd6281, 32'd1000, 32'd0);
    note(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    note(32'd0, 32'hFFFF_FFFF, 32'd0);
    note(32'd2000, 32'd1000, 32'd2000);
    note(32'd2959, 32'd1000, 32'd2000);
    note(32'd2960, 32'd1000, 32'd2000);
    note(32'd1999, 32'd1000, 32'd2000);
    note(32'd0, 32'd0, 32'hFFFF_FFFF);
    note(32'hFFFF_FFFF, 32'd0, 32'd0);
    note(32'd0, 32'd0, 32'd0);
    note(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();
    // tiny sustain and peak put the levels right at the 3 LSB cutoff
    set_envelope(24'd8, 24'd8, 24'd8, 24'd28, 24'd28);
    note(32'd207, 32'd100, 32'd200);
    note(32'd206, 32'd100, 32'd200);
    note(32'd208, 32'd100, 32'd200);
    note(32'd301, 32'd300, 32'd0);
    note(32'd302, 32'd300, 32'd0);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    // zero durations act as one tick
    set_envelope('0, '0, '0, '0, '0);
    send_stream(30, 1'b0);
    wait_idle();
    set_envelope(DUR_MAX, DUR_MAX, DUR_MAX, 24'd32768, 24'd32768);
    send_stream(30, 1'b0);
    wait_idle();
    // levels above full scale, with the upper data bits set
    set_envelope(24'd1, 24'd1, 24'd1, DUR_MAX, DUR_MAX);
    send_stream(30, 1'b0);
    wait_idle();
    // decay rising from a zero peak
    set_envelope(24'd16, 24'd64, 24'd3, 24'd32768, 24'd0);
    send_stream(30, 1'b0);
    wait_idle();
    // unused indexes must leave the registers alone
    for (int i = int'(CFG_PEAK) + 1; i <= CFG_IDX_TOP; i++) begin
      write_reg(CFG_IDX_W'(i), DUR_W'($urandom()));
    end
    send_stream(30, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_notes();
    for (int phase = 0; phase < 7; phase++) begin
      random_config();
      send_stream(150, 1'b0);
      wait_idle();
    end
  endtask

  // Stall the reader long enough that the block fills up and raises in_full.
  task automatic test_backpressure();
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    send_stream(150, 1'b1);
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_envelope_shape();
    test_register_extremes();
    test_backpressure();
    test_random_notes();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_levels.size() != 0) mismatches++;
    $display("summary: %0d note words over %0d register writes, %0d result words checked",
             notes_sent, reg_writes, words_read);
    $display("summary: %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= LONG_HOLD;
      out_pop   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_pop   <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_pop    <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) rx_style <= rx_style_t'($urandom_range(0, 2));
      case (rx_style)
        RX_STREAM: out_pop <= 1'b1;
        RX_COIN:   out_pop <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 24);
            out_pop    <= 1'b0;
          end else begin
            out_pop <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin : check_words
    out_word_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        words_read++;
        if (expected_levels.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result word: level %0d active %0b",
                     out_data.level, out_data.still_active);
        end else begin
          want = expected_levels.pop_front();
          if (out_data.level !== want.level || out_data.still_active !== want.still_active) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch at word %0d: level exp %0d got %0d, active exp %0b got %0b",
                       words_read, want.level, out_data.level,
                       want.still_active, out_data.still_active);
          end
        end
      end
      if (in_push && !in_full) begin
        expected_levels = {expected_levels, predict_level(in_data)};
        notes_sent++;
      end
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          CFG_ATTACK:  cur_attack  = cfg_data;
          CFG_DECAY:   cur_decay   = cfg_data;
          CFG_RELEASE: cur_release = cfg_data;
          CFG_SUSTAIN: cur_sustain = cfg_data[LVL_W-1:0];
          CFG_PEAK:    cur_peak    = cfg_data[LVL_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> adsr_envelope_level_core.f
+incdir+hdl
hdl/adsr_pkg.sv
hdl/adsr_fifo.sv
hdl/adsr_front.sv
hdl/adsr_back.sv
hdl/adsr_envelope_level_core.sv
bench/tb_adsr_envelope_level_core.sv
